### hdl/planar_imu_dead_reckoning_macros.svh
// Assertion macros for the planar dead-reckoning block.
// Assertions compile away when SYNTH is defined; the macros expect clk and arst_n in scope.
`ifndef PLANAR_IMU_DEAD_RECKONING_MACROS_SVH
`define PLANAR_IMU_DEAD_RECKONING_MACROS_SVH
`ifndef SYNTH
`define PIDR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pidr: next-cycle check failed");
`define PIDR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pidr: same-cycle check failed");
`else
`define PIDR_ASSERT_NEXT(lbl, ante, cons)
`define PIDR_ASSERT_NOW(lbl, ante, cons)
`endif
`endif

### hdl/pidr_pkg.sv
// Shared constants, micro-operation codes and the arctangent table.
// No dependencies; used by the controller, the datapath and the top level.
package pidr_pkg;

	localparam int SAMPLE_FRAC_BITS = 16;
	localparam int TRIG_ITER_DEF    = 24;
	localparam int RED_STEPS        = 16;
	localparam int IDX_W            = 5;

	localparam logic [15:0] STEP_RESET = 16'd6554;
	localparam logic [2:0]  ADDR_STEP  = 3'd0;

	localparam logic signed [63:0] PI_Q28       = 64'sd843314857;
	localparam logic signed [63:0] HALF_PI_Q28  = 64'sd421657428;
	localparam logic signed [63:0] TWO_PI_Q28   = 64'sd1686629713;
	localparam logic signed [63:0] GAIN_Q30     = 64'sd652032874;
	localparam logic signed [63:0] S48_MAX      = 64'sd140737488355327;
	localparam logic signed [63:0] S48_MIN      = -64'sd140737488355328;

	localparam logic [4:0] OP_NOP  = 5'd0;
	localparam logic [4:0] OP_LOAD = 5'd1;
	localparam logic [4:0] OP_HMUL = 5'd2;
	localparam logic [4:0] OP_HADD = 5'd3;
	localparam logic [4:0] OP_RED  = 5'd4;
	localparam logic [4:0] OP_HSET = 5'd5;
	localparam logic [4:0] OP_CORD = 5'd6;
	localparam logic [4:0] OP_CFIN = 5'd7;
	localparam logic [4:0] OP_M1   = 5'd8;
	localparam logic [4:0] OP_M2   = 5'd9;
	localparam logic [4:0] OP_M3   = 5'd10;
	localparam logic [4:0] OP_M4   = 5'd11;
	localparam logic [4:0] OP_M5   = 5'd12;
	localparam logic [4:0] OP_TS   = 5'd13;
	localparam logic [4:0] OP_T1   = 5'd14;
	localparam logic [4:0] OP_T2   = 5'd15;
	localparam logic [4:0] OP_T3   = 5'd16;
	localparam logic [4:0] OP_TA   = 5'd17;
	localparam logic [4:0] OP_OUT  = 5'd18;

	localparam logic [1:0] Q_VX = 2'd0;
	localparam logic [1:0] Q_VY = 2'd1;
	localparam logic [1:0] Q_PX = 2'd2;
	localparam logic [1:0] Q_PY = 2'd3;

	typedef struct packed {
		logic [4:0]       op;
		logic [IDX_W-1:0] idx;
		logic [1:0]       qsel;
	} dp_cmd_t;

	function automatic logic [31:0] atan_q30(input logic [IDX_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

### hdl/planar_imu_dead_reckoning.sv
// Planar IMU dead reckoning: one position result per IMU sample.
//
// Input channel (in_valid/in_ready) takes gyro_rate, accel_z, accel_y, all
// signed Q8.16. Output channel (out_valid/out_ready) gives pos_x, pos_y,
// signed Q32.16, saturating. The step_time register (unsigned Q0.16, byte
// address 0) is written and read over the APB port; pready is always high.
// An item is worked on by one sequencer: heading integration, angle wrap,
// TRIG_ITERATIONS CORDIC steps, rotation on the shared 32x32 multiplier and
// trapezoidal velocity and position updates. The sequencer works on one
// item at a time and accepts a new one only after handing the result of
// the last one to the output register and returning to idle.
// Results sit in an output register, so the next item is taken while one
// waits; if the receiver still stalls when the next result is due, the
// sequencer holds until the waiting result is taken.
// Reset clears heading, velocities, positions and history, and loads
// step_time with 6554 (about 0.1 s).
module planar_imu_dead_reckoning
	import pidr_pkg::*;
#(
	parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] gyro_rate,
	input  logic signed [23:0] accel_z,
	input  logic signed [23:0] accel_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y
);

	`include "planar_imu_dead_reckoning_macros.svh"

	logic [15:0] step_q;
	logic        step_wr;
	dp_cmd_t     cmd;

	assign pready  = 1'b1;
	assign step_wr = psel && penable && pwrite && pready && paddr == ADDR_STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_RESET;
		else if (step_wr)
			step_q <= pwdata[15:0];
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_STEP)
			prdata = {16'b0, step_q};
	end

	pidr_ctrl #(
		.TRIG_ITERATIONS(TRIG_ITERATIONS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	pidr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.dt       (step_q),
		.gyro_rate(gyro_rate),
		.accel_z  (accel_z),
		.accel_y  (accel_y),
		.pos_x    (pos_x),
		.pos_y    (pos_y)
	);

	`PIDR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`PIDR_ASSERT_NEXT(a_step_written, step_wr, step_q == $past(pwdata[15:0]))
	`PIDR_ASSERT_NOW(a_load_only_idle, cmd.op == OP_LOAD, in_ready && in_valid)

endmodule

### hdl/pidr_ctrl.sv
// Sequencer for the dead-reckoning datapath: one micro-operation per cycle.
// Depends on pidr_pkg for operation codes and the command struct.
module pidr_ctrl
	import pidr_pkg::*;
#(
	parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_HMUL = 5'd1;
	localparam logic [4:0] S_HADD = 5'd2;
	localparam logic [4:0] S_RED  = 5'd3;
	localparam logic [4:0] S_HSET = 5'd4;
	localparam logic [4:0] S_CORD = 5'd5;
	localparam logic [4:0] S_CFIN = 5'd6;
	localparam logic [4:0] S_M1   = 5'd7;
	localparam logic [4:0] S_M2   = 5'd8;
	localparam logic [4:0] S_M3   = 5'd9;
	localparam logic [4:0] S_M4   = 5'd10;
	localparam logic [4:0] S_M5   = 5'd11;
	localparam logic [4:0] S_TS   = 5'd12;
	localparam logic [4:0] S_T1   = 5'd13;
	localparam logic [4:0] S_T2   = 5'd14;
	localparam logic [4:0] S_T3   = 5'd15;
	localparam logic [4:0] S_TA   = 5'd16;
	localparam logic [4:0] S_DONE = 5'd17;

	localparam logic [IDX_W-1:0] CORD_LAST = IDX_W'(TRIG_ITERATIONS - 1);
	localparam logic [IDX_W-1:0] RED_FIRST = IDX_W'(RED_STEPS - 1);

	logic [4:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [1:0]       qsel_q;
	logic             out_valid_q;
	logic             hand_off;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign hand_off  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.op   = OP_NOP;
		cmd.idx  = cnt_q;
		cmd.qsel = qsel_q;
		unique case (state_q)
			S_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NOP;
			S_HMUL: cmd.op = OP_HMUL;
			S_HADD: cmd.op = OP_HADD;
			S_RED:  cmd.op = OP_RED;
			S_HSET: cmd.op = OP_HSET;
			S_CORD: cmd.op = OP_CORD;
			S_CFIN: cmd.op = OP_CFIN;
			S_M1:   cmd.op = OP_M1;
			S_M2:   cmd.op = OP_M2;
			S_M3:   cmd.op = OP_M3;
			S_M4:   cmd.op = OP_M4;
			S_M5:   cmd.op = OP_M5;
			S_TS:   cmd.op = OP_TS;
			S_T1:   cmd.op = OP_T1;
			S_T2:   cmd.op = OP_T2;
			S_T3:   cmd.op = OP_T3;
			S_TA:   cmd.op = OP_TA;
			S_DONE: cmd.op = hand_off ? OP_OUT : OP_NOP;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			qsel_q      <= Q_VX;
			out_valid_q <= 1'b0;
		end else begin
			if (hand_off)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_HMUL;
				S_HMUL: state_q <= S_HADD;
				S_HADD: begin
					state_q <= S_RED;
					cnt_q   <= RED_FIRST;
				end
				S_RED: begin
					if (cnt_q == '0)
						state_q <= S_HSET;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				S_HSET: begin
					state_q <= S_CORD;
					cnt_q   <= '0;
				end
				S_CORD: begin
					if (cnt_q == CORD_LAST)
						state_q <= S_CFIN;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_CFIN: state_q <= S_M1;
				S_M1:   state_q <= S_M2;
				S_M2:   state_q <= S_M3;
				S_M3:   state_q <= S_M4;
				S_M4:   state_q <= S_M5;
				S_M5: begin
					state_q <= S_TS;
					qsel_q  <= Q_VX;
				end
				S_TS: state_q <= S_T1;
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= S_TA;
				S_TA: begin
					if (qsel_q == Q_PY) begin
						state_q <= S_DONE;
					end else begin
						qsel_q  <= qsel_q + 1'b1;
						state_q <= S_TS;
					end
				end
				S_DONE: if (hand_off) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/pidr_dp.sv
// Datapath: heading integration and wrap, CORDIC sine/cosine, shared multiplier,
// trapezoidal velocity and position updates. Depends on pidr_pkg.
module pidr_dp
	import pidr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic [15:0]         dt,
	input  logic signed [23:0]  gyro_rate,
	input  logic signed [23:0]  accel_z,
	input  logic signed [23:0]  accel_y,
	output logic signed [47:0]  pos_x,
	output logic signed [47:0]  pos_y
);

	localparam int SH  = SAMPLE_FRAC_BITS - 11;
	localparam int SHR = (SH > 0) ? SH : 0;
	localparam int SHL = (SH < 0) ? -SH : 0;
	localparam logic signed [63:0] HRND = (SH > 0) ? (64'sd1 <<< (SHR - 1)) : 64'sd0;
	localparam logic signed [63:0] WRAP_BIAS = TWO_PI_Q28 <<< (RED_STEPS - 1);

	logic signed [23:0] rate_q, az_q, ay_q, prev_rate_q;
	logic signed [31:0] heading_q;
	logic        [47:0] wrap_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [32:0] cz_q;
	logic               neg_q;
	logic signed [31:0] cos_q, sin_q;
	logic signed [63:0] prod_q, acc_q;
	logic signed [25:0] axn_q, ayn_q, pax_q, pay_q;
	logic signed [48:0] tsum_q;
	logic signed [47:0] velx_q, vely_q, pvx_q, pvy_q, posx_q, posy_q, outx_q, outy_q;

	logic signed [24:0] rsum;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic signed [63:0] hd, hadd;
	logic        [47:0] red_sub;
	logic signed [31:0] hnew, hfold;
	logic               hneg;
	logic signed [33:0] shx, shy;
	logic signed [32:0] at;
	logic signed [63:0] tsum_hi_part, tdel, tgt, tres;

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [47:0] r;
		if (v > S48_MAX)
			r = 48'(S48_MAX);
		else if (v < S48_MIN)
			r = 48'(S48_MIN);
		else
			r = 48'(v);
		return r;
	endfunction

	assign rsum  = 25'(rate_q) + 25'(prev_rate_q);
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_HMUL: begin
				mul_a = 32'(rsum);
				mul_b = signed'({16'b0, dt});
			end
			OP_M1: begin
				mul_a = 32'(az_q);
				mul_b = cos_q;
			end
			OP_M2: begin
				mul_a = 32'(ay_q);
				mul_b = sin_q;
			end
			OP_M3: begin
				mul_a = 32'(az_q);
				mul_b = sin_q;
			end
			OP_M4: begin
				mul_a = 32'(ay_q);
				mul_b = cos_q;
			end
			OP_T1: begin
				mul_a = tsum_q[48:17];
				mul_b = signed'({16'b0, dt});
			end
			OP_T2: begin
				mul_a = signed'({15'b0, tsum_q[16:0]});
				mul_b = signed'({16'b0, dt});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// heading increment rounded to Q28, then biased so the wrap works on a positive value
	always_comb begin
		hd      = ((prod_q + HRND) >>> SHR) <<< SHL;
		hadd    = hd + 64'(heading_q) + PI_Q28 + WRAP_BIAS;
		red_sub = wrap_q - (48'(TWO_PI_Q28) << cmd.idx[3:0]);
		hnew    = signed'(wrap_q[31:0]) - 32'(PI_Q28);
		hneg    = 1'b0;
		hfold   = hnew;
		if (64'(hnew) > HALF_PI_Q28) begin
			hfold = hnew - 32'(PI_Q28);
			hneg  = 1'b1;
		end else if (64'(hnew) < -HALF_PI_Q28) begin
			hfold = hnew + 32'(PI_Q28);
			hneg  = 1'b1;
		end
		shx = cx_q >>> cmd.idx;
		shy = cy_q >>> cmd.idx;
		at  = signed'({1'b0, atan_q30(cmd.idx)});
	end

	// trapezoid tail: add rounded low part, then fold into the selected target
	always_comb begin
		tsum_hi_part = (prod_q + 64'sd65536) >>> 17;
		tdel         = acc_q + tsum_hi_part;
		case (cmd.qsel)
			Q_VX:    tgt = 64'(velx_q);
			Q_VY:    tgt = 64'(vely_q);
			Q_PX:    tgt = 64'(posx_q);
			default: tgt = 64'(posy_q);
		endcase
		tres = tgt + acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_rate_q <= '0;
			heading_q   <= '0;
			velx_q      <= '0;
			vely_q      <= '0;
			pax_q       <= '0;
			pay_q       <= '0;
			pvx_q       <= '0;
			pvy_q       <= '0;
			posx_q      <= '0;
			posy_q      <= '0;
		end else begin
			case (cmd.op)
				OP_HADD: prev_rate_q <= rate_q;
				OP_HSET: heading_q   <= hnew;
				OP_TS: begin
					case (cmd.qsel)
						Q_VX:    pax_q <= axn_q;
						Q_VY:    pay_q <= ayn_q;
						Q_PX:    pvx_q <= velx_q;
						default: pvy_q <= vely_q;
					endcase
				end
				OP_TA: begin
					case (cmd.qsel)
						Q_VX:    velx_q <= sat48(tres);
						Q_VY:    vely_q <= sat48(tres);
						Q_PX:    posx_q <= sat48(tres);
						default: posy_q <= sat48(tres);
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (cmd.op)
			OP_LOAD: begin
				rate_q <= gyro_rate;
				az_q   <= accel_z;
				ay_q   <= accel_y;
			end
			OP_HADD: wrap_q <= hadd[47:0];
			OP_RED: begin
				if (wrap_q >= (48'(TWO_PI_Q28) << cmd.idx[3:0]))
					wrap_q <= red_sub;
			end
			OP_HSET: begin
				cx_q  <= 34'(GAIN_Q30);
				cy_q  <= '0;
				cz_q  <= 33'(hfold) <<< 2;
				neg_q <= hneg;
			end
			OP_CORD: begin
				if (!cz_q[32]) begin
					cx_q <= cx_q - shy;
					cy_q <= cy_q + shx;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + shy;
					cy_q <= cy_q - shx;
					cz_q <= cz_q + at;
				end
			end
			OP_CFIN: begin
				cos_q <= neg_q ? 32'(-cx_q) : 32'(cx_q);
				sin_q <= neg_q ? 32'(-cy_q) : 32'(cy_q);
			end
			OP_M2: acc_q <= prod_q;
			OP_M3: axn_q <= 26'((acc_q - prod_q + (64'sd1 <<< 29)) >>> 30);
			OP_M4: acc_q <= prod_q;
			OP_M5: ayn_q <= 26'((acc_q + prod_q + (64'sd1 <<< 29)) >>> 30);
			OP_TS: begin
				case (cmd.qsel)
					Q_VX:    tsum_q <= 49'(axn_q) + 49'(pax_q);
					Q_VY:    tsum_q <= 49'(ayn_q) + 49'(pay_q);
					Q_PX:    tsum_q <= 49'(velx_q) + 49'(pvx_q);
					default: tsum_q <= 49'(vely_q) + 49'(pvy_q);
				endcase
			end
			OP_T2: acc_q <= prod_q;
			OP_T3: acc_q <= tdel;
			OP_OUT: begin
				outx_q <= posx_q;
				outy_q <= posy_q;
			end
			default: ;
		endcase
	end

	assign pos_x = outx_q;
	assign pos_y = outy_q;

endmodule
